### rtl/rc6_pkg.sv
// Shared types and constants for the RC6 mode-0 frame encoder.
`default_nettype none
package rc6_pkg;

  localparam int DATA_BITS  = 20;
  localparam int TOGGLE_POS = 16;
  localparam int ADDR_W     = 8;
  localparam int CMD_W      = 8;
  localparam int TIME_W     = 16;
  localparam int DUR_W      = 17;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int BIT_IDX_W  = $clog2(DATA_BITS);

  localparam int SEG_COUNT = 45;
  localparam int SEG_W     = $clog2(SEG_COUNT);

  // segment positions within a frame
  localparam int SEG_HMARK       = 0;
  localparam int SEG_HSPACE      = 1;
  localparam int SEG_START_MARK  = 2;
  localparam int SEG_START_SPACE = 3;
  localparam int SEG_BITS0       = 4;
  localparam int SEG_TOG_MARK    = SEG_BITS0 + 2 * (DATA_BITS - 1 - TOGGLE_POS);
  localparam int SEG_TOG_SPACE   = SEG_TOG_MARK + 1;
  localparam int SEG_CLOSE       = SEG_COUNT - 1;

  localparam logic [TIME_W-1:0] UNIT_RST   = 16'd444;
  localparam logic [TIME_W-1:0] HMARK_RST  = 16'd2666;
  localparam logic [TIME_W-1:0] HSPACE_RST = 16'd889;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND = 2'd0,
    KIND_AUTO = 2'd1,
    KIND_CLR  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_UNIT      = 2'd1,
    CFG_HDR_MARK  = 2'd2,
    CFG_HDR_SPACE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                 err;
    logic [DATA_BITS-1:0] data;
  } req_t;

endpackage
`default_nettype wire

### rtl/rc6_front.sv
// Front end: accepts request beats, tracks the toggle, queues frame requests.
`default_nettype none
module rc6_front import rc6_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [KIND_W-1:0]   in_kind,
  input  wire [ADDR_W-1:0]   in_address,
  input  wire [CMD_W-1:0]    in_command,
  input  wire                in_toggle,
  input  wire                enable,
  input  wire                q_full,
  output logic               q_push,
  output req_t               q_entry
);

  logic toggle_r, toggle_nxt;
  logic accept;
  logic tog;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    toggle_nxt = toggle_r;
    q_push     = 1'b0;
    tog        = in_toggle;
    case (kind_t'(in_kind))
      KIND_SEND: begin
        q_push = accept;
      end
      KIND_AUTO: begin
        q_push = accept;
        tog    = toggle_r;
        if (accept) begin
          toggle_nxt = ~toggle_r;
        end
      end
      KIND_CLR: begin
        if (accept) begin
          toggle_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    q_entry.err  = !enable;
    q_entry.data = {(DATA_BITS - TOGGLE_POS - 1)'(0), tog, in_address, in_command};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_r <= 1'b0;
    end else begin
      toggle_r <= toggle_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rc6_fifo.sv
// Short request queue between front end and segment sequencer.
`default_nettype none
module rc6_fifo import rc6_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  wire req_t  push_entry,
  output logic       full,
  input  wire        pop,
  output logic       head_valid,
  output req_t       head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full       = cnt_r == CNT_W'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_entry = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rc6_back.sv
// Segment sequencer: plays one queued frame as mark/space beats.
`default_nettype none
module rc6_back import rc6_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  input  wire req_t         q_entry,
  output logic              q_pop,
  input  wire [TIME_W-1:0]  unit_time,
  input  wire [TIME_W-1:0]  hdr_mark,
  input  wire [TIME_W-1:0]  hdr_space,
  output logic              out_valid,
  input  wire               out_ready,
  output logic              out_level,
  output logic [DUR_W-1:0]  out_duration,
  output logic              out_status,
  output logic              out_last
);

  logic [SEG_W-1:0]     seg_r;
  logic                 out_valid_r;
  logic                 level_r, status_r, last_r;
  logic [DUR_W-1:0]     dur_r;

  logic                 adv;
  logic                 last_seg;
  logic                 lvl;
  logic [DUR_W-1:0]     dur;
  logic [SEG_W-1:0]     seg_off;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                 data_bit;
  logic [DUR_W-1:0]     unit_d;

  assign adv   = q_valid && (!out_valid_r || out_ready);
  assign q_pop = adv && last_seg;
  assign unit_d = DUR_W'(unit_time);

  always_comb begin
    seg_off  = seg_r - SEG_W'(SEG_BITS0);
    bit_idx  = BIT_IDX_W'(DATA_BITS - 1) - BIT_IDX_W'(seg_off[SEG_W-1:1]);
    data_bit = q_entry.data[bit_idx];
    last_seg = q_entry.err || (seg_r == SEG_W'(SEG_CLOSE));
    lvl      = data_bit ^ seg_off[0];
    dur      = unit_d;
    case (seg_r)
      SEG_W'(SEG_HMARK): begin
        lvl = 1'b1;
        dur = DUR_W'(hdr_mark);
      end
      SEG_W'(SEG_HSPACE): begin
        lvl = 1'b0;
        dur = DUR_W'(hdr_space);
      end
      SEG_W'(SEG_START_MARK): begin
        lvl = 1'b1;
      end
      SEG_W'(SEG_START_SPACE): begin
        lvl = 1'b0;
      end
      SEG_W'(SEG_TOG_MARK), SEG_W'(SEG_TOG_SPACE): begin
        dur = {unit_time, 1'b0};
      end
      SEG_W'(SEG_CLOSE): begin
        lvl = 1'b0;
      end
      default: begin
      end
    endcase
    if (q_entry.err) begin
      lvl = 1'b0;
      dur = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      seg_r       <= last_seg ? '0 : seg_r + 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      level_r  <= lvl;
      dur_r    <= dur;
      status_r <= q_entry.err ? STATUS_ERR : STATUS_OK;
      last_r   <= last_seg;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_level    = level_r;
  assign out_duration = dur_r;
  assign out_status   = status_r;
  assign out_last     = last_r;

endmodule
`default_nettype wire

### rtl/rc6_ir_frame_encoder.sv
// RC6 mode-0 IR frame encoder: top level with configuration registers.
//
// Each send request becomes a frame of 45 mark/space beats on the result
// channel (level, duration in microseconds), the last one flagged; a send
// while disabled gives one error beat instead. The segment sequencer emits
// one beat per cycle while the receiver does not stall; that sequencer sets
// the throughput. Toggle-reset and unused-kind items are taken at the front
// and produce nothing. A small request queue between front end and
// sequencer lets new requests enter while a frame is still playing. The
// output register holds a finished beat while the receiver stalls, and the
// sequencer waits with it; the next beat is loaded in the cycle the held
// one leaves. A request is written into the queue first, and its first beat
// is then registered in the output register.
`default_nettype none
module rc6_ir_frame_encoder import rc6_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [KIND_W-1:0]     in_kind,
  input  wire [ADDR_W-1:0]     in_address,
  input  wire [CMD_W-1:0]      in_command,
  input  wire                  in_toggle,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_level,
  output logic [DUR_W-1:0]     out_duration,
  output logic                 out_status,
  output logic                 out_last,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [TIME_W-1:0]     cfg_data
);

  logic              enable_r;
  logic [TIME_W-1:0] unit_r, hmark_r, hspace_r;

  logic q_push, q_full, q_pop, q_valid;
  req_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      unit_r   <= UNIT_RST;
      hmark_r  <= HMARK_RST;
      hspace_r <= HSPACE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    enable_r <= cfg_data[0];
        CFG_UNIT:      unit_r   <= cfg_data;
        CFG_HDR_MARK:  hmark_r  <= cfg_data;
        CFG_HDR_SPACE: hspace_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rc6_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_address (in_address),
    .in_command (in_command),
    .in_toggle  (in_toggle),
    .enable     (enable_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  rc6_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  rc6_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_entry      (q_head),
    .q_pop        (q_pop),
    .unit_time    (unit_r),
    .hdr_mark     (hmark_r),
    .hdr_space    (hspace_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_level    (out_level),
    .out_duration (out_duration),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request queue overflow");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && out_duration == '0 && !out_level)
    else $error("error beat malformed");

  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside frame");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_last)
    else $error("queue pop without last beat");

endmodule
`default_nettype wire

### tb/sv/rc6_frame_checker.sv
// Scoreboard for the RC6 frame encoder: predicts each segment beat and compares.
module rc6_frame_checker import rc6_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [CMD_W-1:0]     in_command,
  input  logic                 in_toggle,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_level,
  input  logic [DUR_W-1:0]     out_duration,
  input  logic                 out_status,
  input  logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  output int                   pending,
  output int                   failures,
  output int                   beats
);

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration;
    logic             status;
    logic             last;
  } seg_t;

  seg_t expected_segs[$];
  seg_t want;

  logic              en_q     = 1'b0;
  logic [TIME_W-1:0] unit_q   = UNIT_RST;
  logic [TIME_W-1:0] hmark_q  = HMARK_RST;
  logic [TIME_W-1:0] hspace_q = HSPACE_RST;
  logic              toggle_q = 1'b0;

  int errs   = 0;
  int nbeats = 0;

  task automatic push_seg(input logic lvl, input logic [DUR_W-1:0] dur, input logic fin);
    expected_segs.push_back('{level: lvl, duration: dur, status: STATUS_OK, last: fin});
  endtask

  task automatic encode_frame(input logic tog, input logic [ADDR_W-1:0] addr,
                              input logic [CMD_W-1:0] cmd);
    logic [DATA_BITS-1:0] word;
    logic [DUR_W-1:0]     half;
    word = {3'b000, tog, addr, cmd};
    if (!en_q) begin
      expected_segs.push_back('{level: 1'b0, duration: '0, status: STATUS_ERR, last: 1'b1});
    end else begin
      push_seg(1'b1, DUR_W'(hmark_q), 1'b0);
      push_seg(1'b0, DUR_W'(hspace_q), 1'b0);
      push_seg(1'b1, DUR_W'(unit_q), 1'b0);
      push_seg(1'b0, DUR_W'(unit_q), 1'b0);
      for (int i = DATA_BITS - 1; i >= 0; i--) begin
        half = (i == TOGGLE_POS) ? {unit_q, 1'b0} : DUR_W'(unit_q);
        push_seg(word[i], half, 1'b0);
        push_seg(~word[i], half, 1'b0);
      end
      push_seg(1'b0, DUR_W'(unit_q), 1'b1);
    end
  endtask

  task automatic check_field(input string name, input logic [DUR_W-1:0] exp_v,
                             input logic [DUR_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      en_q     = 1'b0;
      unit_q   = UNIT_RST;
      hmark_q  = HMARK_RST;
      hspace_q = HSPACE_RST;
      toggle_q = 1'b0;
      expected_segs.delete();
    end else begin
      if (out_valid && out_ready) begin
        nbeats++;
        if (expected_segs.size() == 0) begin
          $error("unexpected beat: level %0d duration %0d status %0d last %0d",
                 out_level, out_duration, out_status, out_last);
          errs++;
        end else begin
          want = expected_segs.pop_front();
          check_field("level", want.level, out_level);
          check_field("duration", want.duration, out_duration);
          check_field("status", want.status, out_status);
          check_field("last", want.last, out_last);
        end
      end
      if (in_valid && in_ready) begin
        case (in_kind)
          KIND_CLR:  toggle_q = 1'b0;
          KIND_SEND: encode_frame(in_toggle, in_address, in_command);
          KIND_AUTO: begin
            encode_frame(toggle_q, in_address, in_command);
            toggle_q = ~toggle_q;
          end
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:    en_q     = cfg_data[0];
          CFG_UNIT:      unit_q   = cfg_data;
          CFG_HDR_MARK:  hmark_q  = cfg_data;
          CFG_HDR_SPACE: hspace_q = cfg_data;
          default: ;
        endcase
      end
    end
    pending  <= expected_segs.size();
    failures <= errs;
    beats    <= nbeats;
  end

endmodule

### tb/sv/tb.sv
// Testbench top for the RC6 frame encoder: stimulus, flow control and verdict.
module tb;
  import rc6_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 38;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 4;
  localparam int CYCLE_LIMIT = 600000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind    = '0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic [CMD_W-1:0]     in_command = '0;
  logic                 in_toggle  = 1'b0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic                 out_level;
  logic [DUR_W-1:0]     out_duration;
  logic                 out_status;
  logic                 out_last;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [TIME_W-1:0]    cfg_data   = '0;

  logic quiet    = 1'b0;
  logic hold_req = 1'b0;

  int pending, failures, beats;
  int sent = 0, clears = 0, ignored = 0, settings = 0;
  int unsigned cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rc6_ir_frame_encoder dut (.*);

  rc6_frame_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off
  int   stall_left = 0;
  int   hold_left  = 0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                           input logic [CMD_W-1:0] c, input logic t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_address <= a;
    in_command <= c;
    in_toggle  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (k == KIND_CLR) clears++;
    if (k == KIND_UNUSED) ignored++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [TIME_W-1:0] u,
                            input logic [TIME_W-1:0] hm, input logic [TIME_W-1:0] hs);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= TIME_W'(en);
    @(posedge clk);
    cfg_index <= CFG_UNIT;
    cfg_data  <= u;
    @(posedge clk);
    cfg_index <= CFG_HDR_MARK;
    cfg_data  <= hm;
    @(posedge clk);
    cfg_index <= CFG_HDR_SPACE;
    cfg_data  <= hs;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [KIND_W-1:0] k;
    int                r;
    int                n;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: error beats, auto toggle still flips
    send_item(KIND_SEND, 8'h5a, 8'ha5, 1'b1);
    send_item(KIND_AUTO, 8'h00, 8'hff, 1'b0);
    send_item(KIND_AUTO, 8'hff, 8'h00, 1'b0);
    send_item(KIND_CLR, 8'h12, 8'h34, 1'b1);
    send_item(KIND_UNUSED, 8'hff, 8'hff, 1'b1);
    send_item(KIND_AUTO, 8'h3c, 8'hc3, 1'b1);
    drain();

    set_config(1'b1, UNIT_RST, HMARK_RST, HSPACE_RST);
    send_item(KIND_SEND, 8'h00, 8'h00, 1'b0);
    send_item(KIND_SEND, 8'hff, 8'hff, 1'b1);
    send_item(KIND_SEND, 8'haa, 8'h55, 1'b0);
    send_item(KIND_AUTO, 8'h0f, 8'hf0, 1'b0);
    send_item(KIND_AUTO, 8'hf0, 8'h0f, 1'b0);
    send_item(KIND_CLR, 8'h00, 8'h00, 1'b0);
    send_item(KIND_AUTO, 8'h81, 8'h7e, 1'b1);
    send_item(KIND_UNUSED, 8'h00, 8'h00, 1'b0);
    send_item(KIND_AUTO, 8'h7e, 8'h81, 1'b0);
    send_item(KIND_SEND, 8'h55, 8'haa, 1'b1);
    drain();

    set_config(1'b1, 16'd1, 16'd1, 16'd1);
    send_item(KIND_SEND, 8'h01, 8'h80, 1'b1);
    send_item(KIND_AUTO, 8'h80, 8'h01, 1'b0);
    drain();

    set_config(1'b1, 16'hffff, 16'hffff, 16'hffff);
    send_item(KIND_SEND, 8'hff, 8'h00, 1'b1);
    send_item(KIND_SEND, 8'h00, 8'hff, 1'b0);
    drain();

    // zero times, outside the legal range: zero-length segments
    set_config(1'b1, 16'd0, 16'd0, 16'd0);
    send_item(KIND_SEND, 8'hc3, 8'h3c, 1'b1);
    send_item(KIND_AUTO, 8'h3c, 8'hc3, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) quiet <= 1'b1;
      set_config(p != 1,
                 (p == 3) ? TIME_W'($urandom_range(1, 16)) : TIME_W'($urandom_range(1, 65535)),
                 TIME_W'($urandom_range(1, 65535)), TIME_W'($urandom_range(1, 65535)));
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        k = (r < 42) ? KIND_SEND : (r < 84) ? KIND_AUTO : (r < 94) ? KIND_CLR : KIND_UNUSED;
        if (p == 2 && n == 10) hold_req <= 1'b1;
        if (p == 3 && n == 20) drain();
        send_item(k, ADDR_W'($urandom), CMD_W'($urandom), 1'($urandom));
        if (k != KIND_UNUSED) n++;
      end
      drain();
    end

    $display("Sent %0d requests (%0d toggle clears, %0d unused kinds) over %0d register settings.",
             sent, clears, ignored, settings);
    $display("Compared %0d result beats, with a long receiver hold and mid-run drains.", beats);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
